@@ hw/rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Result word layout, status codes, symbol classes, queue sizing and the
// character classifier.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Most results one input word can produce (a full quantum)
    localparam int MAX_RES    = 3;
    localparam int RES_CW     = $clog2(MAX_RES + 1);

    // Result queue between decode and the output port
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Alphabet landmarks
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam logic [7:0] OFS_LOWER  = 8'd26;
    localparam logic [7:0] OFS_DIGIT  = 8'd52;
    localparam logic [5:0] VAL_PLUS   = 6'd62;
    localparam logic [5:0] VAL_SLASH  = 6'd63;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_INVALID = 3'd1,
        ST_PAD     = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_DONE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SYM_VALUE = 2'd0,
        SYM_PAD   = 2'd1,
        SYM_SPACE = 2'd2,
        SYM_BAD   = 2'd3
    } t_sym_class;

    typedef struct packed {
        t_sym_class  cls;
        logic [5:0]  value;
    } t_symbol;

    typedef struct packed {
        logic [7:0]  data_byte;
        t_status     status;
        logic        last;
    } t_result;

    // Results pushed into the queue in the same cycle, slot 0 first
    typedef struct packed {
        logic [RES_CW-1:0]         count;
        t_result [MAX_RES-1:0]     res;
    } t_push;

    function automatic t_symbol classify(input logic [7:0] c);
        t_symbol    s;
        logic [7:0] d;
        s.cls   = SYM_BAD;
        s.value = '0;
        d       = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d       = c - CH_UPPER_A;
            s.cls   = SYM_VALUE;
            s.value = d[5:0];
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d       = c - CH_LOWER_A + OFS_LOWER;
            s.cls   = SYM_VALUE;
            s.value = d[5:0];
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            d       = c - CH_DIGIT_0 + OFS_DIGIT;
            s.cls   = SYM_VALUE;
            s.value = d[5:0];
        end else if (c == CH_PLUS) begin
            s.cls   = SYM_VALUE;
            s.value = VAL_PLUS;
        end else if (c == CH_SLASH) begin
            s.cls   = SYM_VALUE;
            s.value = VAL_SLASH;
        end else if (c == CH_EQUALS) begin
            s.cls   = SYM_PAD;
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            s.cls   = SYM_SPACE;
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/base64_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_top: streaming base64 decoder
// Standard alphabet, one character or end-of-input mark per word in, one
// decoded byte or status per word out.
// ----------------------------------------------------------------------------
// Each input word (i_kind = 0 with a character, or i_kind = 1 for end of
// input) is taken into an input register, decoded from there once the queue
// has room, and its zero to three result words are written into an
// eight-entry result queue, so a new input word is taken every cycle as long
// as the queue has room for three more results. The output side drains one
// result word per cycle straight from the queue head unless i_stall holds
// it; since four characters give at most three bytes, a steady stream runs
// at one character per cycle with the output never stalled. The first
// result word reaches the output through the input register and the queue.
// Status 0 carries a decoded byte; 1 and 2 mark an invalid character or
// misplaced padding, after which all characters are dropped until end of
// input; end of input yields, unless an error was reported, status 3 for a
// partial quantum or 4 otherwise, and clears all state. o_last flags the
// final result word of each input word. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_in_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_byte;
    logic       fire;
    logic       room;
    logic       in_take;

    b64d_pkg::t_push   push;
    b64d_pkg::t_result head;

    // Advance the held word into decode whenever the queue can absorb a
    // whole quantum; otherwise hold it and stall the input side.
    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_kind;
            r_byte <= i_in_byte;
        end
    end

    b64d_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_kind  (r_kind),
        .i_byte  (r_byte),
        .o_push  (push)
    );

    b64d_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (head)
    );

    assign o_data_byte = head.data_byte;
    assign o_status    = head.status;
    assign o_last      = head.last;

endmodule

@@ hw/rtl/b64d_decode.sv @@
// ----------------------------------------------------------------------------
// b64d_decode: quantum state and per-word decode
// Holds the partial quantum, padding and error flags, and turns one input
// word into zero to three result words combinationally.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_kind,
    input  logic [7:0]       i_byte,
    output b64d_pkg::t_push  o_push
);

    logic [1:0] r_count, n_count;
    logic       r_pad, n_pad;
    logic       r_err, n_err;
    logic [5:0] r_s0, r_s1, r_s2, n_s0, n_s1, n_s2;

    b64d_pkg::t_symbol sym;
    b64d_pkg::t_push   push;
    logic [7:0]        b0, b1, b2;

    always_comb begin
        n_count = r_count;
        n_pad   = r_pad;
        n_err   = r_err;
        n_s0    = r_s0;
        n_s1    = r_s1;
        n_s2    = r_s2;
        push    = '0;
        sym     = b64d_pkg::classify(i_byte);
        b0      = {r_s0, r_s1[5:4]};
        b1      = {r_s1[3:0], r_s2[5:2]};
        b2      = {r_s2[1:0], sym.value};

        if (i_fire) begin
            if (i_kind) begin
                // end of input: report and clear
                if (!r_err) begin
                    push.count         = 2'd1;
                    push.res[0].status = (r_count != 2'd0) ? b64d_pkg::ST_TRUNC
                                                           : b64d_pkg::ST_DONE;
                    push.res[0].last   = 1'b1;
                end
                n_count = 2'd0;
                n_pad   = 1'b0;
                n_err   = 1'b0;
            end else if (!(r_err || (r_pad && r_count == 2'd0))) begin
                case (sym.cls)
                    b64d_pkg::SYM_BAD: begin
                        push.count         = 2'd1;
                        push.res[0].status = b64d_pkg::ST_INVALID;
                        push.res[0].last   = 1'b1;
                        n_err              = 1'b1;
                    end
                    b64d_pkg::SYM_VALUE, b64d_pkg::SYM_PAD: begin
                        case (r_count)
                            2'd0, 2'd1: begin
                                if (sym.cls == b64d_pkg::SYM_PAD) begin
                                    push.count         = 2'd1;
                                    push.res[0].status = b64d_pkg::ST_PAD;
                                    push.res[0].last   = 1'b1;
                                    n_err              = 1'b1;
                                end else begin
                                    if (r_count == 2'd0) begin
                                        n_s0 = sym.value;
                                    end else begin
                                        n_s1 = sym.value;
                                    end
                                    n_count = r_count + 2'd1;
                                end
                            end
                            2'd2: begin
                                if (sym.cls == b64d_pkg::SYM_PAD) begin
                                    n_pad = 1'b1;
                                    n_s2  = '0;
                                end else begin
                                    n_s2  = sym.value;
                                end
                                n_count = 2'd3;
                            end
                            default: begin
                                // fourth symbol closes the quantum
                                push.res[0].data_byte = b0;
                                push.res[0].status    = b64d_pkg::ST_DATA;
                                push.res[1].data_byte = b1;
                                push.res[1].status    = b64d_pkg::ST_DATA;
                                push.res[2].data_byte = b2;
                                push.res[2].status    = b64d_pkg::ST_DATA;
                                if (r_pad) begin
                                    push.count       = 2'd1;
                                    push.res[0].last = 1'b1;
                                end else if (sym.cls == b64d_pkg::SYM_PAD) begin
                                    push.count       = 2'd2;
                                    push.res[1].last = 1'b1;
                                    n_pad            = 1'b1;
                                end else begin
                                    push.count       = 2'd3;
                                    push.res[2].last = 1'b1;
                                end
                                n_count = 2'd0;
                            end
                        endcase
                    end
                    default: begin
                        // whitespace: no result
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
        r_s1 <= n_s1;
        r_s2 <= n_s2;
    end

    assign o_push = push;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_kind) |=> (r_count == 2'd0 && !r_pad && !r_err))
        else $error("state not cleared after end of input");

    a_error_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0 && (push.res[0].status == b64d_pkg::ST_INVALID ||
                                push.res[0].status == b64d_pkg::ST_PAD)) |=> r_err)
        else $error("error reported but not held");

    a_full_quantum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd3) |-> (push.res[2].last && !push.res[1].last && !r_pad))
        else $error("three-byte quantum malformed");

endmodule

@@ hw/rtl/b64d_result_fifo.sv @@
// ----------------------------------------------------------------------------
// b64d_result_fifo: result queue
// Takes up to three result words per cycle and hands out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64d_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64d_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_stall,
    output b64d_pkg::t_result o_result
);

    b64d_pkg::t_result                  r_mem [b64d_pkg::FIFO_DEPTH];
    logic [b64d_pkg::FIFO_AW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [b64d_pkg::FIFO_AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [b64d_pkg::FIFO_CW-1:0]       r_count, n_count;
    logic                               pop;

    assign pop      = (r_count != '0) && !i_stall;
    assign n_wr_ptr = r_wr_ptr + b64d_pkg::FIFO_AW'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + b64d_pkg::FIFO_AW'(pop);
    assign n_count  = r_count + b64d_pkg::FIFO_CW'(i_push.count)
                    - b64d_pkg::FIFO_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < b64d_pkg::MAX_RES; k++) begin
            if (b64d_pkg::RES_CW'(k) < i_push.count) begin
                r_mem[r_wr_ptr + b64d_pkg::FIFO_AW'(k)] <= i_push.res[k];
            end
        end
    end

    assign o_room   = r_count <= b64d_pkg::FIFO_CW'(b64d_pkg::FIFO_DEPTH - b64d_pkg::MAX_RES);
    assign o_valid  = r_count != '0;
    assign o_result = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != '0) |-> o_room)
        else $error("push into queue without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= b64d_pkg::FIFO_CW'(b64d_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the base64 stream decoder
// Drives characters and end-of-input marks with random gaps and stalls,
// predicts each result word from a behavioral decoder and compares every
// field of every result word in order.
// ----------------------------------------------------------------------------
module tb_top;

    // ------------------------------------------------------------------------
    // Byte predictor: a behavioral decoder that queues the result words each
    // accepted input word should produce, then matches them against the DUT.
    // ------------------------------------------------------------------------
    class b64_byte_predictor;
        b64d_pkg::t_result pending_results[$];
        logic [5:0] quantum_syms[3];
        logic [1:0] quantum_len;
        bit         pad_seen;
        bit         err_seen;
        int         fails;

        function new();
            fails = 0;
            clear_state();
        endfunction

        function void clear_state();
            quantum_syms = '{default: 6'd0};
            quantum_len  = 2'd0;
            pad_seen     = 1'b0;
            err_seen     = 1'b0;
        endfunction

        function bit is_blank(input logic [7:0] ch);
            return ch == b64d_pkg::CH_SPACE ||
                   (ch >= b64d_pkg::CH_TAB && ch <= b64d_pkg::CH_CR);
        endfunction

        // Map a character to its symbol class and six-bit value
        function void sort_char(input logic [7:0] ch, output b64d_pkg::t_sym_class cls,
                                output logic [5:0] val);
            logic [7:0] d;
            d   = 8'd0;
            cls = b64d_pkg::SYM_VALUE;
            if (ch >= b64d_pkg::CH_UPPER_A && ch <= b64d_pkg::CH_UPPER_Z)
                d = ch - b64d_pkg::CH_UPPER_A;
            else if (ch >= b64d_pkg::CH_LOWER_A && ch <= b64d_pkg::CH_LOWER_Z)
                d = ch - b64d_pkg::CH_LOWER_A + 8'd26;
            else if (ch >= b64d_pkg::CH_DIGIT_0 && ch <= b64d_pkg::CH_DIGIT_9)
                d = ch - b64d_pkg::CH_DIGIT_0 + 8'd52;
            else if (ch == b64d_pkg::CH_PLUS)
                d = 8'd62;
            else if (ch == b64d_pkg::CH_SLASH)
                d = 8'd63;
            else if (ch == b64d_pkg::CH_EQUALS)
                cls = b64d_pkg::SYM_PAD;
            else if (is_blank(ch))
                cls = b64d_pkg::SYM_SPACE;
            else
                cls = b64d_pkg::SYM_BAD;
            val = d[5:0];
        endfunction

        function void push_result(input logic [7:0] data, input b64d_pkg::t_status st);
            b64d_pkg::t_result r;
            r.data_byte = data;
            r.status    = st;
            r.last      = 1'b0;
            pending_results.push_back(r);
        endfunction

        // Advance the decoder by one accepted input word
        function void note_word(input logic kind, input logic [7:0] ch);
            b64d_pkg::t_sym_class cls;
            logic [5:0] val;
            logic [5:0] s0, s1, s2;
            int         n_before;
            n_before = pending_results.size();
            s0 = quantum_syms[0];
            s1 = quantum_syms[1];
            s2 = quantum_syms[2];
            if (kind) begin
                if (!err_seen)
                    push_result(8'd0, quantum_len != 2'd0 ? b64d_pkg::ST_TRUNC
                                                          : b64d_pkg::ST_DONE);
                clear_state();
            end else if (!err_seen && !(pad_seen && quantum_len == 2'd0)) begin
                sort_char(ch, cls, val);
                if (cls == b64d_pkg::SYM_BAD) begin
                    push_result(8'd0, b64d_pkg::ST_INVALID);
                    err_seen = 1'b1;
                end else if (cls == b64d_pkg::SYM_SPACE) begin
                    // skip
                end else if (quantum_len < 2'd2) begin
                    if (cls == b64d_pkg::SYM_PAD) begin
                        push_result(8'd0, b64d_pkg::ST_PAD);
                        err_seen = 1'b1;
                    end else begin
                        quantum_syms[quantum_len] = val;
                        quantum_len++;
                    end
                end else if (quantum_len == 2'd2) begin
                    if (cls == b64d_pkg::SYM_PAD) begin
                        pad_seen        = 1'b1;
                        quantum_syms[2] = 6'd0;
                    end else begin
                        quantum_syms[2] = val;
                    end
                    quantum_len = 2'd3;
                end else begin
                    push_result({s0, s1[5:4]}, b64d_pkg::ST_DATA);
                    // padding third: any fourth symbol closes with one byte
                    if (!pad_seen) begin
                        push_result({s1[3:0], s2[5:2]}, b64d_pkg::ST_DATA);
                        if (cls == b64d_pkg::SYM_PAD)
                            pad_seen = 1'b1;
                        else
                            push_result({s2[1:0], val}, b64d_pkg::ST_DATA);
                    end
                    quantum_len  = 2'd0;
                    quantum_syms = '{default: 6'd0};
                end
            end
            if (pending_results.size() > n_before)
                pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        // Compare one accepted result word with the oldest pending one
        function void check_word(input logic [7:0] data, input logic [2:0] st,
                                 input logic last);
            b64d_pkg::t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result word: data %02h status %0d last %0b",
                         $time, data, st, last);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            if (data !== want.data_byte) begin
                $display("%0t MISMATCH data_byte: expected %02h, got %02h",
                         $time, want.data_byte, data);
                fails++;
            end
            if (st !== want.status) begin
                $display("%0t MISMATCH status: expected %0d, got %0d",
                         $time, want.status, st);
                fails++;
            end
            if (last !== want.last) begin
                $display("%0t MISMATCH last: expected %0b, got %0b",
                         $time, want.last, last);
                fails++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------------
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       i_kind    = 1'b0;
    logic [7:0] i_in_byte = 8'd0;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_data_byte;
    logic [2:0] o_status;
    logic       o_last;

    b64_byte_predictor byte_pred = new();

    // Traffic shaping, shared by the sender and the receiver
    bit tx_calm   = 1'b0;   // sender offers a word every cycle
    bit rx_calm   = 1'b0;   // receiver never stalls
    bit hold_req  = 1'b0;   // ask the receiver for one long stall
    int hold_left = 0;
    int words_sent = 0;     // input words that are not plain whitespace

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    base64_stream_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_in_byte   (i_in_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data_byte (o_data_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // ------------------------------------------------------------------------
    // Receiver: check each accepted result word, then pick next cycle's stall.
    // A long hold, counted here, lets the result queue fill so that the block
    // has to stall its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            byte_pred.check_word(o_data_byte, o_status, o_last);
        if (hold_req) begin
            hold_left = 60;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (rx_calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 22);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one word after an optional random gap; hold it until accepted
    task automatic send_item(input logic kind, input logic [7:0] ch);
        while (!tx_calm && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_in_byte <= ch;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        byte_pred.note_word(kind, ch);
        if (kind || !byte_pred.is_blank(ch))
            words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(1'b0, s[k]);
    endtask

    // Drop the input and wait until every pending result word has arrived
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (byte_pred.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] sym_char(input int v);
        if (v < 26) return b64d_pkg::CH_UPPER_A + 8'(v);
        if (v < 52) return b64d_pkg::CH_LOWER_A + 8'(v - 26);
        if (v < 62) return b64d_pkg::CH_DIGIT_0 + 8'(v - 52);
        if (v == 62) return b64d_pkg::CH_PLUS;
        return b64d_pkg::CH_SLASH;
    endfunction

    // One alphabet symbol, now and then preceded by whitespace
    task automatic send_symbol();
        logic [7:0] blank;
        if ($urandom_range(9) == 0) begin
            blank = ($urandom_range(5) == 0) ? b64d_pkg::CH_SPACE
                                             : b64d_pkg::CH_TAB + 8'($urandom_range(4));
            send_item(1'b0, blank);
        end
        send_item(1'b0, sym_char($urandom_range(63)));
    endtask

    // Mostly well-formed messages with random content and a random ending;
    // the rest is noise that leaves the decoder in whatever state it reaches.
    task automatic send_random_message();
        int n_quanta;
        int ending;
        int n_extra;
        n_quanta = $urandom_range(3);
        ending   = $urandom_range(9);
        if (ending >= 8) begin
            n_extra = $urandom_range(6, 1);
            repeat (n_extra)
                send_item($urandom_range(7) == 0, 8'($urandom_range(255)));
        end else begin
            repeat (n_quanta) repeat (4) send_symbol();
            case (ending)
                1: begin
                    repeat (2) send_symbol();
                    send_item(1'b0, b64d_pkg::CH_EQUALS);
                    send_item(1'b0, b64d_pkg::CH_EQUALS);
                end
                2: begin
                    repeat (3) send_symbol();
                    send_item(1'b0, b64d_pkg::CH_EQUALS);
                end
                3: begin
                    repeat (2) send_symbol();
                    send_item(1'b0, b64d_pkg::CH_EQUALS);
                    send_symbol();
                end
                4: begin
                    n_extra = $urandom_range(3, 1);
                    repeat (n_extra) send_symbol();
                end
                5: begin
                    // break the stream with an arbitrary byte mid-quantum
                    n_extra = $urandom_range(3);
                    repeat (n_extra) send_symbol();
                    send_item(1'b0, 8'($urandom_range(255)));
                end
                default: begin
                    // end on a quantum boundary
                end
            endcase
            if ($urandom_range(4) == 0)
                send_item(1'b0, 8'($urandom_range(255)));
            send_item(1'b1, 8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int  rand_start;
        int  done_cnt;
        bit  paused;
        paused = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full quantum with whitespace and the two top symbols
        send_item(1'b0, "T");
        send_item(1'b0, b64d_pkg::CH_TAB);
        send_text("W+/");
        // padding third, then padding fourth: one byte; later chars dropped
        send_text("TQ==!");
        send_item(1'b1, 8'hA5);
        // padding fourth: two bytes
        send_text("TWE=");
        send_item(1'b1, 8'h00);
        // padding first: error, end after error gives nothing
        send_item(1'b0, b64d_pkg::CH_EQUALS);
        send_item(1'b1, 8'hFF);
        // padding third with no fourth symbol: truncated
        send_text("AB=");
        send_item(1'b1, 8'h5A);
        // padding third, then an alphabet symbol: one byte
        send_text("QU=Z");
        send_item(1'b1, 8'h01);
        // invalid character
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h80);
        pause_until_drained();

        // Random: no sender gaps at first while the receiver holds off long
        // enough for the result queue to fill, later a full drain, then a
        // stretch where neither side idles.
        rand_start = words_sent;
        hold_req   = 1'b1;
        while (words_sent - rand_start < 150) begin
            tx_calm = (words_sent - rand_start < 40) ||
                      (words_sent - rand_start >= 100 && words_sent - rand_start < 130);
            rx_calm = (words_sent - rand_start >= 100 && words_sent - rand_start < 130);
            if (!paused && words_sent - rand_start >= 75) begin
                pause_until_drained();
                paused = 1'b1;
            end
            send_random_message();
        end

        // Drain, then keep clocking with the input idle so stray words would show
        i_valid <= 1'b0;
        tx_calm  = 1'b0;
        rx_calm  = 1'b1;
        done_cnt = 0;
        while (byte_pred.pending_results.size() != 0 && done_cnt < 5000) begin
            @(posedge i_clk);
            done_cnt++;
        end
        repeat (16) @(posedge i_clk);

        if (byte_pred.fails == 0 && byte_pred.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule
